// ----- design/tfgc_pkg.sv -----
// ----------------------------------------------------------------------------
// tfgc_pkg: thermostat fan gear controller package
// Item types, register indexes, microcode control word and the program ROM.
// ----------------------------------------------------------------------------
package tfgc_pkg;

    localparam int TEMP_W         = 12;
    localparam int LIMIT_W        = 8;
    localparam int STEP_W         = 2;
    localparam int WAIT_W         = 16;
    localparam int DUTY_W         = 12;
    localparam int GEAR_W         = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int PC_W           = 3;

    localparam int DUTY_PERIOD_DEFAULT = 3600;

    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GEAR_STEP   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CONV_WAIT   = 2'd3;

    localparam logic signed [LIMIT_W-1:0] UPPER_LIMIT_RST = 8'sd30;
    localparam logic signed [LIMIT_W-1:0] LOWER_LIMIT_RST = 8'sd10;
    localparam logic [STEP_W-1:0]         GEAR_STEP_RST   = 2'd1;
    localparam logic [WAIT_W-1:0]         CONV_WAIT_RST   = 16'd2700;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 12'sh800;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sh7FF;

    localparam logic [GEAR_W-1:0] GEAR_OFF = 2'd0;
    localparam logic [GEAR_W-1:0] GEAR_1   = 2'd1;
    localparam logic [GEAR_W-1:0] GEAR_2   = 2'd2;
    localparam logic [GEAR_W-1:0] GEAR_3   = 2'd3;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [PC_W-1:0] STEP_FETCH      = 3'd0;
    localparam logic [PC_W-1:0] STEP_DISPATCH   = 3'd1;
    localparam logic [PC_W-1:0] STEP_SAMPLE_CMP = 3'd2;
    localparam logic [PC_W-1:0] STEP_SAMPLE_GR  = 3'd3;
    localparam logic [PC_W-1:0] STEP_TICK_WAIT  = 3'd4;
    localparam logic [PC_W-1:0] STEP_TICK_DUTY  = 3'd5;

    typedef struct packed {
        logic                     command;
        logic signed [TEMP_W-1:0] raw_temperature;
    } in_item_t;

    typedef struct packed {
        logic                     fan_drive;
        logic                     relay_on;
        logic [GEAR_W-1:0]        fan_gear;
        logic                     above_upper;
        logic                     below_lower;
        logic                     conversion_ready;
        logic signed [TEMP_W-1:0] highest_seen;
        logic signed [TEMP_W-1:0] lowest_seen;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SAMPLE_CMP,
        OP_SAMPLE_GEAR,
        OP_TICK_WAIT,
        OP_TICK_DUTY
    } op_t;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_ITEM,
        COND_IS_TICK
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic            emit;
        logic [PC_W-1:0] target;
        logic [PC_W-1:0] next_step;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] addr);
        ctrl_t w;
        w = '{op: OP_NOP, cond: COND_NEVER, emit: 1'b0,
              target: STEP_FETCH, next_step: STEP_FETCH};
        unique case (addr)
            STEP_FETCH: begin
                w = '{op: OP_ACCEPT, cond: COND_NO_ITEM, emit: 1'b0,
                      target: STEP_FETCH, next_step: STEP_DISPATCH};
            end
            STEP_DISPATCH: begin
                w = '{op: OP_NOP, cond: COND_IS_TICK, emit: 1'b0,
                      target: STEP_TICK_WAIT, next_step: STEP_SAMPLE_CMP};
            end
            STEP_SAMPLE_CMP: begin
                w = '{op: OP_SAMPLE_CMP, cond: COND_NEVER, emit: 1'b0,
                      target: STEP_FETCH, next_step: STEP_SAMPLE_GR};
            end
            STEP_SAMPLE_GR: begin
                w = '{op: OP_SAMPLE_GEAR, cond: COND_NEVER, emit: 1'b1,
                      target: STEP_FETCH, next_step: STEP_FETCH};
            end
            STEP_TICK_WAIT: begin
                w = '{op: OP_TICK_WAIT, cond: COND_NEVER, emit: 1'b0,
                      target: STEP_FETCH, next_step: STEP_TICK_DUTY};
            end
            STEP_TICK_DUTY: begin
                w = '{op: OP_TICK_DUTY, cond: COND_NEVER, emit: 1'b1,
                      target: STEP_FETCH, next_step: STEP_FETCH};
            end
            default: begin
                w = '{op: OP_NOP, cond: COND_NEVER, emit: 1'b0,
                      target: STEP_FETCH, next_step: STEP_FETCH};
            end
        endcase
        return w;
    endfunction

endpackage

// ----- design/thermostat_fan_gear_controller_core.sv -----
// ----------------------------------------------------------------------------
// thermostat_fan_gear_controller_core
// Microcoded controller for fan gear, heater relay, conversion wait and
// fan duty drive, fed by timer ticks and temperature samples.
// ----------------------------------------------------------------------------
//  channel  | ports                         | item
//  ---------+-------------------------------+-------------------------------
//  input    | s_valid s_ready s_data        | tick or temperature sample
//  result   | m_valid m_ready m_data        | drive, relay, gear, flags, extremes
//  config   | cfg_we cfg_index cfg_wdata    | register write, no wait
//
//  Each item runs through fetch, dispatch and two datapath steps of the
//  microprogram ROM, the last of which loads the result register.
//  The next item is taken in the cycle after the result is loaded.
//  A full result register stalls the last step until m_ready frees it.
//  Reset (aresetn low, synchronous) restores registers and state to defaults.
// ----------------------------------------------------------------------------
module thermostat_fan_gear_controller_core #(
    parameter int DUTY_PERIOD = tfgc_pkg::DUTY_PERIOD_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tfgc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tfgc_pkg::out_item_t                 m_data,
    input  logic                                cfg_we,
    input  logic [tfgc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tfgc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import tfgc_pkg::*;

    localparam logic [DUTY_W-1:0] DUTY_SEG1 = DUTY_W'(DUTY_PERIOD * 2 / 5);
    localparam logic [DUTY_W-1:0] DUTY_SEG2 = DUTY_W'(DUTY_PERIOD * 7 / 10);
    localparam logic [DUTY_W-1:0] DUTY_END  = DUTY_W'(DUTY_PERIOD);

    logic signed [LIMIT_W-1:0] upper_limit_reg;
    logic signed [LIMIT_W-1:0] lower_limit_reg;
    logic [STEP_W-1:0]         gear_step_reg;
    logic [WAIT_W-1:0]         conv_wait_reg;

    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_t           ctrl;
    logic            cond_hit;
    logic            out_busy;
    logic            stall;

    logic                     cmd_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [TEMP_W-1:0]        diff_reg, diff_next;

    logic signed [TEMP_W-1:0] max_temp_reg, max_temp_next;
    logic signed [TEMP_W-1:0] min_temp_reg, min_temp_next;
    logic [WAIT_W-1:0]        wait_count_reg, wait_count_next;
    logic                     ready_flag_reg, ready_flag_next;
    logic [DUTY_W-1:0]        duty_count_reg, duty_count_next;
    logic                     motor_en_reg, motor_en_next;
    logic [GEAR_W-1:0]        gear_reg, gear_next;
    logic                     over_reg, over_next;
    logic                     under_reg, under_next;
    logic                     drive_reg, drive_next;
    logic                     relay_reg, relay_next;

    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg;
    out_item_t                result_next;

    logic signed [TEMP_W-1:0] up16;
    logic signed [TEMP_W-1:0] lo16;
    logic signed [TEMP_W:0]   diff_wide;
    logic [TEMP_W-1:0]        step16;
    logic [TEMP_W-1:0]        step32;
    logic [WAIT_W-1:0]        wait_inc;
    logic [DUTY_W-1:0]        duty_inc;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_limit_reg <= UPPER_LIMIT_RST;
            lower_limit_reg <= LOWER_LIMIT_RST;
            gear_step_reg   <= GEAR_STEP_RST;
            conv_wait_reg   <= CONV_WAIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_UPPER_LIMIT: upper_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_LOWER_LIMIT: lower_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_GEAR_STEP:   gear_step_reg   <= cfg_wdata[STEP_W-1:0];
                REG_CONV_WAIT:   conv_wait_reg   <= cfg_wdata[WAIT_W-1:0];
                default:         upper_limit_reg <= upper_limit_reg;
            endcase
        end
    end

    // sequencer
    assign ctrl     = ucode_rom(pc_reg);
    assign out_busy = m_valid_reg && !m_ready;
    assign stall    = ctrl.emit && out_busy;
    assign s_ready  = (ctrl.op == OP_ACCEPT);

    always_comb begin
        unique case (ctrl.cond)
            COND_NEVER:   cond_hit = 1'b0;
            COND_NO_ITEM: cond_hit = !s_valid;
            COND_IS_TICK: cond_hit = (cmd_reg == CMD_TICK);
            default:      cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        priority if (stall) begin
            pc_next = pc_reg;
        end else if (cond_hit) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = ctrl.next_step;
        end
    end

    // datapath
    assign up16      = {upper_limit_reg, 4'b0000};
    assign lo16      = {lower_limit_reg, 4'b0000};
    assign diff_wide = {temp_reg[TEMP_W-1], temp_reg} - {up16[TEMP_W-1], up16};
    assign step16    = {{(TEMP_W-STEP_W-4){1'b0}}, gear_step_reg, 4'b0000};
    assign step32    = {{(TEMP_W-STEP_W-5){1'b0}}, gear_step_reg, 5'b00000};
    assign wait_inc  = wait_count_reg + WAIT_W'(1);
    assign duty_inc  = duty_count_reg + DUTY_W'(1);

    always_comb begin
        max_temp_next   = max_temp_reg;
        min_temp_next   = min_temp_reg;
        wait_count_next = wait_count_reg;
        ready_flag_next = ready_flag_reg;
        duty_count_next = duty_count_reg;
        motor_en_next   = motor_en_reg;
        gear_next       = gear_reg;
        over_next       = over_reg;
        under_next      = under_reg;
        drive_next      = drive_reg;
        relay_next      = relay_reg;
        diff_next       = diff_reg;
        if (!stall) begin
            unique case (ctrl.op)
                OP_NOP, OP_ACCEPT: begin
                    diff_next = diff_reg;
                end
                OP_SAMPLE_CMP: begin
                    ready_flag_next = 1'b0;
                    if (temp_reg > max_temp_reg) max_temp_next = temp_reg;
                    if (temp_reg < min_temp_reg) min_temp_next = temp_reg;
                    over_next     = (temp_reg > up16);
                    motor_en_next = (temp_reg > up16);
                    under_next    = (temp_reg < lo16);
                    relay_next    = (temp_reg < lo16);
                    diff_next     = diff_wide[TEMP_W-1:0];
                end
                OP_SAMPLE_GEAR: begin
                    priority if (!over_reg) begin
                        gear_next = GEAR_OFF;
                    end else if (gear_step_reg == '0) begin
                        gear_next = GEAR_3;
                    end else if (diff_reg >= step32) begin
                        gear_next = GEAR_3;
                    end else if (diff_reg >= step16) begin
                        gear_next = GEAR_2;
                    end else begin
                        gear_next = GEAR_1;
                    end
                end
                OP_TICK_WAIT: begin
                    if (!ready_flag_reg) begin
                        if (wait_inc >= conv_wait_reg) begin
                            wait_count_next = '0;
                            ready_flag_next = 1'b1;
                        end else begin
                            wait_count_next = wait_inc;
                        end
                    end
                end
                OP_TICK_DUTY: begin
                    if (motor_en_reg) begin
                        duty_count_next = duty_inc;
                        priority if (duty_inc < DUTY_SEG1) begin
                            drive_next = (gear_reg >= GEAR_1);
                        end else if (duty_inc < DUTY_SEG2) begin
                            drive_next = (gear_reg >= GEAR_2);
                        end else if (duty_inc < DUTY_END) begin
                            drive_next = (gear_reg >= GEAR_3);
                        end else begin
                            duty_count_next = '0;
                        end
                    end else begin
                        drive_next = 1'b0;
                    end
                end
                default: begin
                    diff_next = diff_reg;
                end
            endcase
        end
    end

    always_comb begin
        result_next.fan_drive        = drive_next;
        result_next.relay_on         = relay_next;
        result_next.fan_gear         = gear_next;
        result_next.above_upper      = over_next;
        result_next.below_lower      = under_next;
        result_next.conversion_ready = ready_flag_next;
        result_next.highest_seen     = max_temp_next;
        result_next.lowest_seen      = min_temp_next;
    end

    always_comb begin
        priority if (ctrl.emit && !out_busy) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= STEP_FETCH;
            cmd_reg        <= CMD_TICK;
            max_temp_reg   <= TEMP_MIN;
            min_temp_reg   <= TEMP_MAX;
            wait_count_reg <= '0;
            ready_flag_reg <= 1'b0;
            duty_count_reg <= '0;
            motor_en_reg   <= 1'b0;
            gear_reg       <= GEAR_OFF;
            over_reg       <= 1'b0;
            under_reg      <= 1'b0;
            drive_reg      <= 1'b0;
            relay_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pc_reg         <= pc_next;
            if (s_valid && s_ready) cmd_reg <= s_data.command;
            max_temp_reg   <= max_temp_next;
            min_temp_reg   <= min_temp_next;
            wait_count_reg <= wait_count_next;
            ready_flag_reg <= ready_flag_next;
            duty_count_reg <= duty_count_next;
            motor_en_reg   <= motor_en_next;
            gear_reg       <= gear_next;
            over_reg       <= over_next;
            under_reg      <= under_next;
            drive_reg      <= drive_next;
            relay_reg      <= relay_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) temp_reg <= s_data.raw_temperature;
        diff_reg <= diff_next;
        if (ctrl.emit && !out_busy) m_data_reg <= result_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (pc_reg == STEP_DISPATCH))
        else $error("accepted item did not advance to dispatch");

    a_gear_matches_over: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.fan_gear != GEAR_OFF) == m_data.above_upper))
        else $error("fan gear disagrees with upper limit flag");

    a_extremes_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.highest_seen < m_data.lowest_seen)) |->
        ((m_data.highest_seen == TEMP_MIN) && (m_data.lowest_seen == TEMP_MAX)))
        else $error("highest below lowest after a sample");

endmodule

// ----- test/thermostat_fan_gear_controller_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermostat_fan_gear_controller_core_test: self-checking bench
// Drives ticks and temperature samples through the valid/ready input channel
// under several limit, step and wait settings. A scoreboard keeps its own
// copy of the controller state, predicts the status word for every accepted
// item and compares each result field by field. Both channels idle at random,
// the receiver holds off for long stretches, and a tick run with the fan on
// advances the fan duty counter.
// ----------------------------------------------------------------------------
module thermostat_fan_gear_controller_core_test;

    import tfgc_pkg::*;

    class fan_gear_scoreboard;
        localparam int DUTY_LEN = DUTY_PERIOD_DEFAULT;
        localparam int SEG1_END = DUTY_LEN * 2 / 5;
        localparam int SEG2_END = DUTY_LEN * 7 / 10;

        logic signed [LIMIT_W-1:0] upper_deg;
        logic signed [LIMIT_W-1:0] lower_deg;
        logic [STEP_W-1:0]         deg_per_gear;
        logic [WAIT_W-1:0]         wait_limit;

        logic signed [TEMP_W-1:0]  peak;
        logic signed [TEMP_W-1:0]  trough;
        logic [WAIT_W-1:0]         wait_cnt;
        logic [DUTY_W-1:0]         duty;
        logic [GEAR_W-1:0]         gear;
        bit                        ready;
        bit                        motor;
        bit                        over;
        bit                        under;
        bit                        drive;
        bit                        relay;

        out_item_t                 status_q[$];
        int                        errors;

        function new();
            upper_deg    = UPPER_LIMIT_RST;
            lower_deg    = LOWER_LIMIT_RST;
            deg_per_gear = GEAR_STEP_RST;
            wait_limit   = CONV_WAIT_RST;
            peak         = TEMP_MIN;
            trough       = TEMP_MAX;
            wait_cnt     = '0;
            duty         = '0;
            gear         = GEAR_OFF;
            ready        = 0;
            motor        = 0;
            over         = 0;
            under        = 0;
            drive        = 0;
            relay        = 0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_UPPER_LIMIT: upper_deg    = val[LIMIT_W-1:0];
                REG_LOWER_LIMIT: lower_deg    = val[LIMIT_W-1:0];
                REG_GEAR_STEP:   deg_per_gear = val[STEP_W-1:0];
                REG_CONV_WAIT:   wait_limit   = val[WAIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(in_item_t it);
            int        t;
            int        up;
            int        lo;
            int        q;
            out_item_t e;
            if (it.command == CMD_SAMPLE) begin
                t  = int'(it.raw_temperature);
                up = upper_deg * 16;
                lo = lower_deg * 16;
                ready = 0;
                if (t > peak) peak = TEMP_W'(t);
                if (t < trough) trough = TEMP_W'(t);
                if (t > up) begin
                    over  = 1;
                    motor = 1;
                    if (deg_per_gear == 0) begin
                        gear = GEAR_3;
                    end else begin
                        q    = (t - up) / (int'(deg_per_gear) * 16) + 1;
                        gear = (q > 3) ? GEAR_3 : q[GEAR_W-1:0];
                    end
                end else begin
                    over  = 0;
                    motor = 0;
                    gear  = GEAR_OFF;
                end
                under = t < lo;
                relay = under;
            end else begin
                if (!ready) begin
                    wait_cnt = wait_cnt + 1'b1;
                    if (wait_cnt >= wait_limit) begin
                        wait_cnt = '0;
                        ready    = 1;
                    end
                end
                if (motor) begin
                    duty = duty + 1'b1;
                    if (duty < SEG1_END) begin
                        drive = gear >= GEAR_1;
                    end else if (duty < SEG2_END) begin
                        drive = gear >= GEAR_2;
                    end else if (duty < DUTY_LEN) begin
                        drive = gear == GEAR_3;
                    end else begin
                        duty = '0;
                    end
                end else begin
                    drive = 0;
                end
            end
            e.fan_drive        = drive;
            e.relay_on         = relay;
            e.fan_gear         = gear;
            e.above_upper      = over;
            e.below_lower      = under;
            e.conversion_ready = ready;
            e.highest_seen     = peak;
            e.lowest_seen      = trough;
            status_q.push_back(e);
        endfunction

        function void field_check(string name, logic [TEMP_W-1:0] want, logic [TEMP_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_item(out_item_t got);
            out_item_t e;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            e = status_q.pop_front();
            field_check("fan_drive", TEMP_W'(e.fan_drive), TEMP_W'(got.fan_drive));
            field_check("relay_on", TEMP_W'(e.relay_on), TEMP_W'(got.relay_on));
            field_check("fan_gear", TEMP_W'(e.fan_gear), TEMP_W'(got.fan_gear));
            field_check("above_upper", TEMP_W'(e.above_upper), TEMP_W'(got.above_upper));
            field_check("below_lower", TEMP_W'(e.below_lower), TEMP_W'(got.below_lower));
            field_check("conversion_ready", TEMP_W'(e.conversion_ready),
                        TEMP_W'(got.conversion_ready));
            field_check("highest_seen", e.highest_seen, got.highest_seen);
            field_check("lowest_seen", e.lowest_seen, got.lowest_seen);
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    fan_gear_scoreboard     sb = new();
    bit                     steady = 0;
    int                     hold_requests = 0;

    thermostat_fan_gear_controller_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("thermostat_fan_gear_controller_core_test NOT OK");
        $finish;
    end

    // result side: random stalls plus long hold-offs on request
    initial begin : sink
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && holds_done != hold_requests) begin
                holds_done++;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || $urandom_range(0, 99) >= 9;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_item(m_data);
    end

    function automatic in_item_t item_of(logic cmd, int temp);
        in_item_t it;
        it.command         = cmd;
        it.raw_temperature = TEMP_W'(temp);
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        int       centre;
        it.command = ($urandom_range(0, 99) < 55) ? CMD_TICK : CMD_SAMPLE;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.raw_temperature = TEMP_W'($urandom);
        end else if (pick < 90) begin
            centre = (pick < 70) ? sb.upper_deg * 16 : sb.lower_deg * 16;
            centre = centre + int'($urandom_range(0, 128)) - 64;
            if (centre > 2047) centre = 2047;
            if (centre < -2048) centre = -2048;
            it.raw_temperature = TEMP_W'(centre);
        end else begin
            it.raw_temperature = $urandom_range(0, 1) ? TEMP_MAX : TEMP_MIN;
        end
        return it;
    endfunction

    task automatic push_item(input in_item_t it);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
    endtask

    // drop valid and wait for every expected result
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        case (idx)
            REG_UPPER_LIMIT, REG_LOWER_LIMIT: data[LIMIT_W-1:0] = LIMIT_W'(val);
            REG_GEAR_STEP:                    data[STEP_W-1:0]  = STEP_W'(val);
            default:                          data              = CFG_DATA_W'(val);
        endcase
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        in_item_t it;
        int       pick;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: extremes, limit edges, gear steps
        push_item(item_of(CMD_TICK, 0));
        push_item(item_of(CMD_SAMPLE, 2047));
        push_item(item_of(CMD_SAMPLE, -2048));
        push_item(item_of(CMD_SAMPLE, 480));
        push_item(item_of(CMD_SAMPLE, 481));
        push_item(item_of(CMD_SAMPLE, 496));
        push_item(item_of(CMD_SAMPLE, 512));
        push_item(item_of(CMD_SAMPLE, 160));
        push_item(item_of(CMD_SAMPLE, 159));
        push_item(item_of(CMD_SAMPLE, 0));
        push_item(item_of(CMD_TICK, -1));
        push_item(item_of(CMD_SAMPLE, 481));
        push_item(item_of(CMD_TICK, 0));
        push_item(item_of(CMD_TICK, 0));

        // zero step saturates the gear
        settle();
        write_reg(REG_GEAR_STEP, 0);
        push_item(item_of(CMD_SAMPLE, 481));
        push_item(item_of(CMD_TICK, 0));

        // lower the wait below the running count
        settle();
        write_reg(REG_CONV_WAIT, 65535);
        push_item(item_of(CMD_TICK, 0));
        push_item(item_of(CMD_TICK, 0));
        push_item(item_of(CMD_TICK, 0));
        settle();
        write_reg(REG_CONV_WAIT, 2);
        push_item(item_of(CMD_TICK, 0));

        // zero wait: ready on the first tick after a sample
        settle();
        write_reg(REG_CONV_WAIT, 0);
        push_item(item_of(CMD_SAMPLE, 200));
        push_item(item_of(CMD_TICK, 0));

        for (int p = 0; p < 7; p++) begin
            settle();
            case (p)
                0: begin
                    write_reg(REG_UPPER_LIMIT, -128);
                    write_reg(REG_LOWER_LIMIT, 127);
                    write_reg(REG_GEAR_STEP, 3);
                    write_reg(REG_CONV_WAIT, 1);
                end
                1: begin
                    write_reg(REG_UPPER_LIMIT, 127);
                    write_reg(REG_LOWER_LIMIT, -128);
                    write_reg(REG_GEAR_STEP, 0);
                    write_reg(REG_CONV_WAIT, 65535);
                end
                default: begin
                    write_reg(REG_UPPER_LIMIT, $urandom_range(0, 255));
                    write_reg(REG_LOWER_LIMIT, $urandom_range(0, 255));
                    write_reg(REG_GEAR_STEP, $urandom_range(0, 3));
                    pick = $urandom_range(0, 9);
                    if (pick < 3) write_reg(REG_CONV_WAIT, $urandom_range(0, 3));
                    else if (pick < 8) write_reg(REG_CONV_WAIT, $urandom_range(1, 50));
                    else write_reg(REG_CONV_WAIT, $urandom_range(0, 65535));
                end
            endcase
            steady = (p == 3);
            for (int i = 0; i < 100; i++) begin
                if ((p == 2 || p == 5) && i == 40) hold_requests++;
                push_item(random_item());
            end
        end
        steady = 0;

        // tick run with the fan on: advance the duty counter
        settle();
        write_reg(REG_UPPER_LIMIT, 20);
        write_reg(REG_LOWER_LIMIT, -128);
        write_reg(REG_GEAR_STEP, 1);
        write_reg(REG_CONV_WAIT, $urandom_range(1, 30));
        for (int i = 0; i < 330; i++) begin
            it.raw_temperature = TEMP_W'($urandom);
            it.command         = CMD_TICK;
            pick = $urandom_range(0, 999);
            if (i == 0 || pick < 30) begin
                it.command         = CMD_SAMPLE;
                it.raw_temperature = TEMP_W'(321 + $urandom_range(0, 79));
            end else if (pick < 35) begin
                it.command         = CMD_SAMPLE;
                it.raw_temperature = TEMP_W'($urandom_range(0, 320));
            end
            if (i == 150) hold_requests++;
            push_item(it);
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("thermostat_fan_gear_controller_core_test OK");
        end else begin
            $display("thermostat_fan_gear_controller_core_test NOT OK");
        end
        $finish;
    end

endmodule
